@@ rtl/core/dpq_pkg.sv @@
package dpq_pkg;

  localparam int COORD_BITS       = 16;
  localparam int DIST_W           = 2 * COORD_BITS;
  localparam int DEFAULT_CAPACITY = 64;
  localparam int PENDING_W        = 7;
  localparam int STATUS_W         = 3;

  localparam logic [1:0] CMD_SCHEDULE   = 2'd0;
  localparam logic [1:0] CMD_UNSCHEDULE = 2'd1;
  localparam logic [1:0] CMD_POP        = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_PRESENT     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_PRESENT = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY       = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL        = 3'd4;

  localparam logic [1:0] OP_HOLD   = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  typedef struct packed {
    logic [1:0]                   command;
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
  } dpq_in_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] out_x;
    logic signed [COORD_BITS-1:0] out_y;
    logic [STATUS_W-1:0]          status;
    logic [PENDING_W-1:0]         pending;
    logic                         not_empty;
  } dpq_out_t;

  typedef struct packed {
    logic                         valid;
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic [DIST_W-1:0]            dist_sq;
  } dpq_entry_t;

  typedef struct packed {
    logic [1:0]                   op;
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic [DIST_W-1:0]            dist_sq;
  } dpq_ctrl_t;

endpackage

@@ rtl/core/dpq_dist.sv @@
module dpq_dist (
  input  logic                                  clk,
  input  logic signed [dpq_pkg::COORD_BITS-1:0] pos_x,
  input  logic signed [dpq_pkg::COORD_BITS-1:0] pos_y,
  output logic [dpq_pkg::DIST_W-1:0]            dist_sq
);
  import dpq_pkg::*;

  logic [COORD_BITS-1:0] ax;
  logic [COORD_BITS-1:0] ay;
  logic [DIST_W-1:0]     sq_x_r;
  logic [DIST_W-1:0]     sq_y_r;
  logic [DIST_W-1:0]     dist_r;

  // magnitude fits unsigned even for the most negative coordinate
  assign ax = pos_x[COORD_BITS-1] ? $unsigned(-pos_x) : $unsigned(pos_x);
  assign ay = pos_y[COORD_BITS-1] ? $unsigned(-pos_y) : $unsigned(pos_y);

  always_ff @(posedge clk) begin
    sq_x_r <= DIST_W'(ax) * DIST_W'(ax);
    sq_y_r <= DIST_W'(ay) * DIST_W'(ay);
    dist_r <= sq_x_r + sq_y_r;
  end

  assign dist_sq = dist_r;

endmodule

@@ rtl/core/dpq_cell.sv @@
module dpq_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  dpq_pkg::dpq_ctrl_t  ctrl,
  input  logic                prev_gt,
  input  dpq_pkg::dpq_entry_t prev_ent,
  input  dpq_pkg::dpq_entry_t next_ent,
  input  logic                shift,
  output dpq_pkg::dpq_entry_t ent,
  output logic                gt,
  output logic                match
);
  import dpq_pkg::*;

  logic                         valid_r;
  logic signed [COORD_BITS-1:0] x_r;
  logic signed [COORD_BITS-1:0] y_r;
  logic [DIST_W-1:0]            dist_r;
  dpq_entry_t                   ent_nxt;

  assign ent   = '{valid: valid_r, x: x_r, y: y_r, dist_sq: dist_r};
  assign gt    = !valid_r || (dist_r > ctrl.dist_sq);
  assign match = valid_r && (x_r == ctrl.x) && (y_r == ctrl.y);

  always_comb begin
    ent_nxt = ent;
    case (ctrl.op)
      OP_INSERT: begin
        // cells past the insertion point move up by one
        if (gt) begin
          if (prev_gt) begin
            ent_nxt = prev_ent;
          end else begin
            ent_nxt = '{valid: 1'b1, x: ctrl.x, y: ctrl.y, dist_sq: ctrl.dist_sq};
          end
        end
      end
      OP_REMOVE: begin
        if (shift) begin
          ent_nxt = next_ent;
        end
      end
      default: begin
        ent_nxt = ent;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= ent_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= ent_nxt.x;
    y_r    <= ent_nxt.y;
    dist_r <= ent_nxt.dist_sq;
  end

endmodule

@@ rtl/core/distance_priority_queue.sv @@
// Set of up to CAPACITY distinct signed grid positions kept sorted by squared
// distance from the origin, nearest first, in a row of cells. Commands are
// schedule (insert unless present or full), unschedule (remove if present) and
// pop (remove and return the nearest); equal distances pop in schedule order.
// Every command gives exactly one result word with status and pending count.
// The squaring unit registers the squares in S_SQUARE and their sum in S_SUM,
// with the cell match compare in S_SQUARE and the match prefix in S_SUM; in
// S_APPLY the cell row updates and the result word is registered. The block
// then returns to idle and takes no new command until the last is applied;
// an unread result word holds the update and with it the input.
module distance_priority_queue #(
  parameter int CAPACITY = dpq_pkg::DEFAULT_CAPACITY
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  dpq_pkg::dpq_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output dpq_pkg::dpq_out_t out_data
);
  import dpq_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int LVLS  = $clog2(CAPACITY);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SQUARE = 2'd1;
  localparam logic [1:0] S_SUM    = 2'd2;
  localparam logic [1:0] S_APPLY  = 2'd3;

  logic [1:0]                   state_r;
  logic [1:0]                   state_nxt;
  logic [1:0]                   cmd_r;
  logic signed [COORD_BITS-1:0] x_r;
  logic signed [COORD_BITS-1:0] y_r;
  logic [CNT_W-1:0]             count_r;
  logic [CNT_W-1:0]             count_nxt;
  logic [CAPACITY-1:0]          match_r;
  logic [CAPACITY-1:0]          after_r;
  logic [CAPACITY-1:0]          after_nxt;
  logic                         out_valid_r;
  dpq_out_t                     out_data_r;

  logic [DIST_W-1:0]            dist_sq;
  dpq_ctrl_t                    cell_ctrl;
  logic [CAPACITY-1:0]          shift_vec;
  logic [CAPACITY-1:0]          match_vec;
  logic [CAPACITY-1:0]          valid_vec;
  logic [CAPACITY:0]            gt_ext;
  dpq_entry_t                   ent_ext [CAPACITY+2];

  logic                         go;
  logic                         present;
  logic                         full;
  logic [STATUS_W-1:0]          status;
  logic signed [COORD_BITS-1:0] rx;
  logic signed [COORD_BITS-1:0] ry;
  logic [CNT_W+PENDING_W-1:0]   cnt_ext;

  dpq_dist u_dist (
    .clk     (clk),
    .pos_x   (x_r),
    .pos_y   (y_r),
    .dist_sq (dist_sq)
  );

  assign gt_ext[0]           = 1'b0;
  assign ent_ext[0]          = '0;
  assign ent_ext[CAPACITY+1] = '0;

  for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
    dpq_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (cell_ctrl),
      .prev_gt  (gt_ext[gi]),
      .prev_ent (ent_ext[gi]),
      .next_ent (ent_ext[gi+2]),
      .shift    (shift_vec[gi]),
      .ent      (ent_ext[gi+1]),
      .gt       (gt_ext[gi+1]),
      .match    (match_vec[gi])
    );
    assign valid_vec[gi] = ent_ext[gi+1].valid;
  end

  // prefix or: a cell shifts down when the match sits at or below it
  always_comb begin
    after_nxt = match_r;
    for (int l = 0; l < LVLS; l++) begin
      after_nxt = after_nxt | (after_nxt << (1 << l));
    end
  end

  assign present  = after_r[CAPACITY-1];
  assign full     = (count_r == CNT_W'(CAPACITY));
  assign go       = (state_r == S_APPLY) && (!out_valid_r || out_ready);
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cell_ctrl = '{op: OP_HOLD, x: x_r, y: y_r, dist_sq: dist_sq};
    shift_vec = after_r;
    status    = ST_DONE;
    rx        = '0;
    ry        = '0;
    count_nxt = count_r;
    if (go) begin
      case (cmd_r)
        CMD_SCHEDULE: begin
          if (present) begin
            status = ST_PRESENT;
          end else if (full) begin
            status = ST_FULL;
          end else begin
            cell_ctrl.op = OP_INSERT;
            count_nxt    = count_r + 1'b1;
          end
        end
        CMD_UNSCHEDULE: begin
          if (!present) begin
            status = ST_NOT_PRESENT;
          end else begin
            cell_ctrl.op = OP_REMOVE;
            count_nxt    = count_r - 1'b1;
          end
        end
        CMD_POP: begin
          if (count_r == '0) begin
            status = ST_EMPTY;
          end else begin
            cell_ctrl.op = OP_REMOVE;
            shift_vec    = '1;
            rx           = ent_ext[1].x;
            ry           = ent_ext[1].y;
            count_nxt    = count_r - 1'b1;
          end
        end
        default: begin
          status = ST_DONE;
        end
      endcase
    end
  end

  assign cnt_ext = {{PENDING_W{1'b0}}, count_nxt};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_SQUARE;
        end
      end
      S_SQUARE: state_nxt = S_SUM;
      S_SUM:    state_nxt = S_APPLY;
      S_APPLY: begin
        if (go) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r <= in_data.command;
      x_r   <= in_data.pos_x;
      y_r   <= in_data.pos_y;
    end
    if (state_r == S_SQUARE) begin
      match_r <= match_vec;
    end
    if (state_r == S_SUM) begin
      after_r <= after_nxt;
    end
    if (go) begin
      out_data_r.out_x     <= rx;
      out_data_r.out_y     <= ry;
      out_data_r.status    <= status;
      out_data_r.pending   <= cnt_ext[PENDING_W-1:0];
      out_data_r.not_empty <= (count_nxt != '0);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_valid_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_vec) == int'(count_r))
    else $error("cell valid bits disagree with entry count");

  a_unique_match: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match_vec))
    else $error("position held in more than one cell");

  a_result_from_apply: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_APPLY)
    else $error("result word raised outside the update cycle");

endmodule

@@ tb/distance_priority_queue_tb.sv @@
`timescale 1ns / 100ps

module distance_priority_queue_tb;
  import dpq_pkg::*;

  localparam int QUEUE_DEPTH = DEFAULT_CAPACITY;
  localparam logic [1:0] CMD_RESERVED = 2'd3;
  localparam int POOL_SIZE = 96;
  localparam int LONG_STALL = 300;
  localparam int SETTLE_CYCLES = 20;
  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_REPORTS = 10;
  localparam logic signed [COORD_BITS-1:0] EDGE_COORDS [5] =
    '{16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff, 16'sh0001};

  typedef enum int {
    FLOW_FREE,
    FLOW_SENDER_GAPS,
    FLOW_RECEIVER_GAPS,
    FLOW_BOTH_LIGHT
  } flow_mode_t;

  logic     clk;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  dpq_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  dpq_out_t out_data;

  distance_priority_queue dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // predicted contents of the cell row, nearest first
  logic signed [COORD_BITS-1:0] held_x    [QUEUE_DEPTH];
  logic signed [COORD_BITS-1:0] held_y    [QUEUE_DEPTH];
  logic [DIST_W-1:0]            held_dist [QUEUE_DEPTH];
  int                           held_count = 0;

  dpq_in_t  command_backlog [$];
  dpq_out_t awaited_replies [$];

  flow_mode_t flow = FLOW_FREE;
  logic       in_fire = 1'b0;
  int         stall_trigger = 0;
  int         stall_seen = 0;
  int         stall_left = 0;
  int         failure_count = 0;
  int         cycle_count = 0;

  logic signed [COORD_BITS-1:0] pool_x [POOL_SIZE];
  logic signed [COORD_BITS-1:0] pool_y [POOL_SIZE];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [DIST_W-1:0] square_dist(logic signed [COORD_BITS-1:0] x,
                                                    logic signed [COORD_BITS-1:0] y);
    longint ax;
    longint ay;
    ax = x;
    ay = y;
    return DIST_W'(ax * ax + ay * ay);
  endfunction

  function automatic int find_held(logic signed [COORD_BITS-1:0] x,
                                   logic signed [COORD_BITS-1:0] y);
    int i;
    for (i = 0; i < held_count; i++) begin
      if (held_x[i] == x && held_y[i] == y) return i;
    end
    return -1;
  endfunction

  function automatic void drop_held(int k);
    int i;
    for (i = k; i + 1 < held_count; i++) begin
      held_x[i] = held_x[i + 1];
      held_y[i] = held_y[i + 1];
      held_dist[i] = held_dist[i + 1];
    end
    held_count--;
  endfunction

  function automatic dpq_out_t apply_command(dpq_in_t word);
    dpq_out_t          reply;
    logic [DIST_W-1:0] d;
    int                k;
    int                i;
    reply = '0;
    reply.status = ST_DONE;
    case (word.command)
      CMD_SCHEDULE: begin
        if (find_held(word.pos_x, word.pos_y) >= 0) begin
          reply.status = ST_PRESENT;
        end else if (held_count >= QUEUE_DEPTH) begin
          reply.status = ST_FULL;
        end else begin
          // goes behind every held position of equal or smaller distance
          d = square_dist(word.pos_x, word.pos_y);
          k = 0;
          while (k < held_count && held_dist[k] <= d) k++;
          for (i = held_count; i > k; i--) begin
            held_x[i] = held_x[i - 1];
            held_y[i] = held_y[i - 1];
            held_dist[i] = held_dist[i - 1];
          end
          held_x[k] = word.pos_x;
          held_y[k] = word.pos_y;
          held_dist[k] = d;
          held_count++;
        end
      end
      CMD_UNSCHEDULE: begin
        k = find_held(word.pos_x, word.pos_y);
        if (k < 0) begin
          reply.status = ST_NOT_PRESENT;
        end else begin
          drop_held(k);
        end
      end
      CMD_POP: begin
        if (held_count == 0) begin
          reply.status = ST_EMPTY;
        end else begin
          reply.out_x = held_x[0];
          reply.out_y = held_y[0];
          drop_held(0);
        end
      end
      default: begin
      end
    endcase
    reply.pending = PENDING_W'(held_count);
    reply.not_empty = held_count != 0;
    return reply;
  endfunction

  function automatic logic idle_roll(int pct);
    return $urandom_range(99) < pct;
  endfunction

  task automatic flag_failure(string msg);
    failure_count++;
    if (failure_count <= MAX_REPORTS) $display("mismatch: %s", msg);
  endtask

  // sender: a word stays on the bus until taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (command_backlog.size() != 0 &&
          !idle_roll(flow == FLOW_SENDER_GAPS ? 65 : flow == FLOW_BOTH_LIGHT ? 7 : 0)) begin
        in_valid <= 1'b1;
        in_data <= command_backlog.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver, with a long hold-off whenever the trigger count moves
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_seen != stall_trigger) begin
      stall_seen <= stall_trigger;
      stall_left <= LONG_STALL;
      out_ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !idle_roll(flow == FLOW_RECEIVER_GAPS ? 65 :
                              flow == FLOW_BOTH_LIGHT ? 7 : 0);
    end
  end

  always @(posedge clk) begin : check_replies
    dpq_out_t want;
    if (!rst_n) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        awaited_replies.insert(awaited_replies.size(), apply_command(in_data));
      end
      if (out_valid && out_ready) begin
        if (awaited_replies.size() == 0) begin
          flag_failure($sformatf("unexpected word x=%0d y=%0d status=%0d pending=%0d ne=%0b",
                                 out_data.out_x, out_data.out_y, out_data.status,
                                 out_data.pending, out_data.not_empty));
        end else begin
          want = awaited_replies.pop_front();
          if (out_data.out_x !== want.out_x || out_data.out_y !== want.out_y ||
              out_data.status !== want.status || out_data.pending !== want.pending ||
              out_data.not_empty !== want.not_empty) begin
            flag_failure({
              $sformatf("expected x=%0d y=%0d status=%0d pending=%0d ne=%0b, ",
                        want.out_x, want.out_y, want.status, want.pending,
                        want.not_empty),
              $sformatf("got x=%0d y=%0d status=%0d pending=%0d ne=%0b",
                        out_data.out_x, out_data.out_y, out_data.status,
                        out_data.pending, out_data.not_empty)});
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("distance_priority_queue regression: fail");
      $finish;
    end
  end

  task automatic push_item(logic [1:0] cmd, logic signed [COORD_BITS-1:0] x,
                           logic signed [COORD_BITS-1:0] y);
    dpq_in_t word;
    word.command = cmd;
    word.pos_x = x;
    word.pos_y = y;
    command_backlog.insert(command_backlog.size(), word);
  endtask

  // wait until every queued word is taken and every reply is back
  task automatic drain();
    while (command_backlog.size() != 0 || in_valid || awaited_replies.size() != 0)
      @(posedge clk);
  endtask

  task automatic push_random_burst(int count, int sched_pct, int unsched_pct, int pop_pct);
    int                           roll;
    int                           k;
    logic [1:0]                   cmd;
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    repeat (count) begin
      roll = $urandom_range(99);
      if (roll < sched_pct) cmd = CMD_SCHEDULE;
      else if (roll < sched_pct + unsched_pct) cmd = CMD_UNSCHEDULE;
      else if (roll < sched_pct + unsched_pct + pop_pct) cmd = CMD_POP;
      else cmd = CMD_RESERVED;
      if (idle_roll(85)) begin
        k = $urandom_range(POOL_SIZE - 1);
        x = pool_x[k];
        y = pool_y[k];
      end else begin
        x = COORD_BITS'($urandom);
        y = COORD_BITS'($urandom);
      end
      push_item(cmd, x, y);
    end
  endtask

  // fills the row exactly, probes present-before-full and full, then empties it;
  // positions come in mirrored pairs so equal distances are common
  task automatic push_fill_run();
    int                           room;
    int                           i;
    int                           j;
    logic signed [COORD_BITS-1:0] a;
    logic signed [COORD_BITS-1:0] b;
    logic signed [COORD_BITS-1:0] first_x;
    logic signed [COORD_BITS-1:0] first_y;
    room = QUEUE_DEPTH - held_count;
    for (i = 0; i < room; i++) begin
      j = i / 2;
      a = COORD_BITS'(7 + j);
      b = COORD_BITS'(40 + j);
      if (idle_roll(50)) a = -a;
      if (idle_roll(50)) b = -b;
      if (i % 2 == 0) push_item(CMD_SCHEDULE, a, b);
      else push_item(CMD_SCHEDULE, b, a);
      if (i == 0) begin
        first_x = a;
        first_y = b;
      end
    end
    if (room > 0) push_item(CMD_SCHEDULE, first_x, first_y);
    push_item(CMD_SCHEDULE, 16'sh0123, -16'sh0456);
    push_item(CMD_SCHEDULE, 16'sh7fff, 16'sh8000);
    if (room > 0) begin
      push_item(CMD_UNSCHEDULE, first_x, first_y);
      push_item(CMD_SCHEDULE, 16'sh7fff, 16'sh8000);
      push_item(CMD_SCHEDULE, first_x, first_y);
    end
    repeat (QUEUE_DEPTH + 2) push_item(CMD_POP, COORD_BITS'($urandom), COORD_BITS'($urandom));
  endtask

  initial begin : stimulus
    int i;
    int seg;
    int roll;
    for (i = 0; i < POOL_SIZE; i++) begin
      roll = $urandom_range(99);
      if (roll < 50) begin
        pool_x[i] = COORD_BITS'($urandom_range(12)) - 16'sd6;
        pool_y[i] = COORD_BITS'($urandom_range(12)) - 16'sd6;
      end else if (roll < 75) begin
        pool_x[i] = COORD_BITS'($urandom);
        pool_y[i] = COORD_BITS'($urandom);
      end else begin
        pool_x[i] = EDGE_COORDS[$urandom_range(4)];
        pool_y[i] = EDGE_COORDS[$urandom_range(4)];
      end
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    push_item(CMD_POP, 16'sh7fff, 16'sh8000);
    push_item(CMD_UNSCHEDULE, 16'sd1, 16'sd1);
    push_item(CMD_RESERVED, 16'shffff, 16'shffff);
    push_item(CMD_SCHEDULE, 16'sh8000, 16'sh8000);
    push_item(CMD_SCHEDULE, 16'sh7fff, 16'sh7fff);
    push_item(CMD_SCHEDULE, 16'sd0, 16'sd0);
    push_item(CMD_SCHEDULE, 16'sd3, 16'sd4);
    push_item(CMD_SCHEDULE, 16'sd4, 16'sd3);
    push_item(CMD_SCHEDULE, -16'sd5, 16'sd0);
    push_item(CMD_SCHEDULE, 16'sd0, -16'sd5);
    push_item(CMD_SCHEDULE, 16'sd3, 16'sd4);
    push_item(CMD_UNSCHEDULE, 16'sd4, 16'sd3);
    push_item(CMD_UNSCHEDULE, 16'sd4, 16'sd3);
    push_item(CMD_SCHEDULE, 16'sh8000, 16'sh7fff);
    push_item(CMD_SCHEDULE, 16'sh7fff, 16'sh8000);
    push_item(CMD_RESERVED, 16'sh8000, 16'sh7fff);
    repeat (9) push_item(CMD_POP, COORD_BITS'($urandom), COORD_BITS'($urandom));
    drain();

    for (seg = 0; seg < 12; seg++) begin
      flow = flow_mode_t'(seg % 4);
      case (seg % 3)
        0: push_random_burst(100, 60, 15, 20);
        1: push_random_burst(100, 40, 25, 30);
        default: push_random_burst(100, 25, 15, 55);
      endcase
      // receiver holds off while the sender keeps offering
      if (seg == 4) stall_trigger++;
      if (seg == 2 || seg == 7) begin
        drain();
        push_fill_run();
      end
      if (seg % 4 == 3) drain();
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (failure_count == 0) begin
      $display("distance_priority_queue regression: pass");
    end else begin
      $display("distance_priority_queue regression: fail");
    end
    $finish;
  end

endmodule
